// File: rtl/pmd_pkg.sv
// Shared types and constants of the PS/2 mouse packet decoder.
package pmd_pkg;

  localparam logic [7:0] AckByte    = 8'hFA;
  localparam int unsigned SyncBit   = 3;
  localparam int unsigned XSignBit  = 4;
  localparam int unsigned YSignBit  = 5;

  localparam int unsigned SizeW     = 13;
  localparam int unsigned PosW      = 12;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 2'd1;

  localparam logic [SizeW-1:0] WidthReset  = 13'd1024;
  localparam logic [SizeW-1:0] HeightReset = 13'd768;
  localparam logic [PosW-1:0]  PosXReset   = 12'd512;
  localparam logic [PosW-1:0]  PosYReset   = 12'd384;
  localparam logic [SizeW-1:0] SizeMax     = 13'd4096;

  // Decoded packet handed from the framer to the top level.
  typedef struct packed {
    logic              fire;
    logic [2:0]        buttons;
    logic signed [8:0] delta_x;
    logic signed [9:0] delta_y;
  } pkt_t;

endpackage

// File: rtl/pmd_byte_if.sv
// Handshake channel carrying raw mouse bytes.
interface pmd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] mouse_byte;

  modport source (output valid, output mouse_byte, input ready);
  modport sink (input valid, input mouse_byte, output ready);
endinterface

// File: rtl/pmd_result_if.sv
// Handshake channel carrying decoded packets and cursor position.
interface pmd_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         buttons;
  logic signed [8:0]  delta_x;
  logic signed [9:0]  delta_y;
  logic [11:0]        pointer_x;
  logic [11:0]        pointer_y;

  modport source (output valid, output buttons, output delta_x, output delta_y,
                  output pointer_x, output pointer_y, input ready);
  modport sink (input valid, input buttons, input delta_x, input delta_y,
                input pointer_x, input pointer_y, output ready);
endinterface

// File: rtl/pmd_cfg_if.sv
// Configuration write channel: register index and data.
interface pmd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/pmd_framer.sv
// Ack wait and three-byte packet framing.
module pmd_framer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    byte_i,
  input  logic          step_i,
  output pmd_pkg::pkt_t pkt_o
);

  typedef enum logic [1:0] {
    PhHeader,
    PhDx,
    PhDy
  } phase_e;

  logic       ack_q, ack_d;
  phase_e     phase_q, phase_d;
  logic [7:0] hdr_q, hdr_d;
  logic [7:0] dx_q, dx_d;
  logic       fire;
  logic signed [9:0] dy_ext;

  always_comb begin
    ack_d   = ack_q;
    phase_d = phase_q;
    hdr_d   = hdr_q;
    dx_d    = dx_q;
    fire    = 1'b0;
    if (!ack_q) begin
      if (byte_i == pmd_pkg::AckByte) ack_d = 1'b1;
    end else begin
      case (phase_q)
        PhHeader: begin
          if (byte_i[pmd_pkg::SyncBit]) begin
            hdr_d   = byte_i;
            phase_d = PhDx;
          end
        end
        PhDx: begin
          dx_d    = byte_i;
          phase_d = PhDy;
        end
        default: begin
          phase_d = PhHeader;
          fire    = 1'b1;
        end
      endcase
    end
  end

  // dy sign-extended to 10 bits, then negated so positive is downward
  assign dy_ext = {hdr_q[pmd_pkg::YSignBit], hdr_q[pmd_pkg::YSignBit], byte_i};

  assign pkt_o.fire    = fire;
  assign pkt_o.buttons = hdr_q[2:0];
  assign pkt_o.delta_x = {hdr_q[pmd_pkg::XSignBit], dx_q};
  assign pkt_o.delta_y = -dy_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_q   <= 1'b0;
      phase_q <= PhHeader;
      hdr_q   <= '0;
      dx_q    <= '0;
    end else if (step_i) begin
      ack_q   <= ack_d;
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      dx_q    <= dx_d;
    end
  end

endmodule

// File: rtl/pmd_cursor.sv
// Cursor position keeper with clamping to the screen size.
module pmd_cursor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          upd_i,
  input  logic signed [8:0]             delta_x_i,
  input  logic signed [9:0]             delta_y_i,
  input  logic [pmd_pkg::SizeW-1:0]     width_i,
  input  logic [pmd_pkg::SizeW-1:0]     height_i,
  output logic [pmd_pkg::PosW-1:0]      pos_x_o,
  output logic [pmd_pkg::PosW-1:0]      pos_y_o
);

  logic [pmd_pkg::PosW-1:0] pos_x_q, pos_x_d;
  logic [pmd_pkg::PosW-1:0] pos_y_q, pos_y_d;

  function automatic logic [pmd_pkg::PosW-1:0] move_clamp(
    input logic [pmd_pkg::PosW-1:0]  pos,
    input logic signed [9:0]         d,
    input logic [pmd_pkg::SizeW-1:0] size
  );
    logic [pmd_pkg::SizeW-1:0] lim;
    logic [13:0]               sum;
    logic [pmd_pkg::PosW-1:0]  res;
    lim = size;
    if (size == '0) lim = 13'd1;
    else if (size > pmd_pkg::SizeMax) lim = pmd_pkg::SizeMax;
    sum = {2'b00, pos} + {{4{d[9]}}, d};
    if (sum[13]) res = '0;
    else if (sum[12:0] >= lim) res = pmd_pkg::PosW'(lim - 13'd1);
    else res = sum[11:0];
    return res;
  endfunction

  assign pos_x_d = move_clamp(pos_x_q, {delta_x_i[8], delta_x_i}, width_i);
  assign pos_y_d = move_clamp(pos_y_q, delta_y_i, height_i);
  assign pos_x_o = pos_x_d;
  assign pos_y_o = pos_y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= pmd_pkg::PosXReset;
      pos_y_q <= pmd_pkg::PosYReset;
    end else if (upd_i) begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
    end
  end

endmodule

// File: rtl/ps2_mouse_packet_decoder_top.sv
// Top level of the PS/2 mouse packet decoder.
// Raw mouse bytes enter on in_i, one per cycle when ready is high. All bytes
// are discarded until the acknowledge byte 0xFA is seen; afterwards bytes are
// framed as header/dx/dy, a header without bit 3 set is dropped for resync.
// Each complete packet yields one item on out_o with buttons, sign-extended
// deltas (dy negated, positive down) and the cursor clamped to the screen
// size set through cfg_i (index 0 width, 1 height; sizes of 0 act as 1, above
// 4096 as 4096). Throughput is one byte per cycle while the input is not
// stalled. The third byte of a packet sits in the input register while
// the framing and cursor adder/clamp logic feed the output register.
// The output register only stalls the input when it is full and not drained.
// Screen size writes do not move the cursor and apply from the next packet.
module ps2_mouse_packet_decoder_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  pmd_byte_if.sink     in_i,
  pmd_result_if.source out_o,
  pmd_cfg_if.sink      cfg_i
);

  // configuration registers
  logic [pmd_pkg::SizeW-1:0] width_q, height_q;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;

  // output register
  logic              out_valid_q;
  logic [2:0]        buttons_q;
  logic signed [8:0] delta_x_q;
  logic signed [9:0] delta_y_q;
  logic [11:0]       pointer_x_q, pointer_y_q;

  pmd_pkg::pkt_t pkt;
  logic [pmd_pkg::PosW-1:0] pos_x, pos_y;
  logic out_free, step, emit, in_take;

  assign out_free = !out_valid_q || out_o.ready;
  // a byte in the input register moves on unless it completes a packet
  // while the output register is blocked
  assign step     = s1_valid_q && (!pkt.fire || out_free);
  assign emit     = step && pkt.fire;
  assign in_i.ready = !s1_valid_q || step;
  assign in_take  = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  pmd_framer u_framer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (s1_byte_q),
    .step_i (step),
    .pkt_o  (pkt)
  );

  pmd_cursor u_cursor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (emit),
    .delta_x_i (pkt.delta_x),
    .delta_y_i (pkt.delta_y),
    .width_i   (width_q),
    .height_i  (height_q),
    .pos_x_o   (pos_x),
    .pos_y_o   (pos_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pmd_pkg::WidthReset;
      height_q <= pmd_pkg::HeightReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pmd_pkg::RegScreenWidth:  width_q  <= cfg_i.data;
        pmd_pkg::RegScreenHeight: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) s1_byte_q <= in_i.mouse_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      buttons_q   <= pkt.buttons;
      delta_x_q   <= pkt.delta_x;
      delta_y_q   <= pkt.delta_y;
      pointer_x_q <= pos_x;
      pointer_y_q <= pos_y;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.buttons   = buttons_q;
  assign out_o.delta_x   = delta_x_q;
  assign out_o.delta_y   = delta_y_q;
  assign out_o.pointer_x = pointer_x_q;
  assign out_o.pointer_y = pointer_y_q;

endmodule

// File: bench/ps2_mouse_packet_decoder_top_tb.sv
// Self-checking testbench for the PS/2 mouse packet decoder: random byte streams vs. a cursor tracker.
module ps2_mouse_packet_decoder_top_tb;

  // Index with no register behind it; a write there must leave both sizes alone.
  localparam logic [pmd_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  // Cycles after the last report before the block counts as idle (two-stage pipe plus margin).
  localparam int unsigned SettleCycles = 4;
  // Receiver hold-off used to back the block up into its input.
  localparam int unsigned HoldOffCycles = 150;

  typedef enum logic [1:0] {
    FrameHeader,
    FrameDx,
    FrameDy
  } frame_pos_e;

  // One decoded packet as it should leave the block.
  typedef struct {
    logic [2:0]                buttons;
    logic signed [8:0]         delta_x;
    logic signed [9:0]         delta_y;
    logic [pmd_pkg::PosW-1:0]  pointer_x;
    logic [pmd_pkg::PosW-1:0]  pointer_y;
  } cursor_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pmd_byte_if   in_if ();
  pmd_result_if out_if ();
  pmd_cfg_if    cfg_if ();

  ps2_mouse_packet_decoder_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Bytes still to be offered; the head is the one on the wire while valid is high.
  logic [7:0]     mouse_bytes_q[$];
  // Packet reports predicted but not yet seen on the output.
  cursor_report_t pending_reports[$];

  // Idle shaping, in percent of cycles, set per phase by the sequencer.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;
  event        hold_off_go;

  int unsigned fail_count = 0;

  // Tracker state: a private copy of what the decoder keeps.
  logic [pmd_pkg::SizeW-1:0] scr_width  = pmd_pkg::WidthReset;
  logic [pmd_pkg::SizeW-1:0] scr_height = pmd_pkg::HeightReset;
  logic                      synced     = 1'b0;
  frame_pos_e                frame_pos  = FrameHeader;
  logic [7:0]                hdr_byte   = '0;
  logic [7:0]                dx_byte    = '0;
  logic [pmd_pkg::PosW-1:0]  pos_x      = pmd_pkg::PosXReset;
  logic [pmd_pkg::PosW-1:0]  pos_y      = pmd_pkg::PosYReset;

  // Move one axis and clamp into 0 .. size-1. A size of 0 acts as 1,
  // anything over 4096 as 4096 (the position is only 12 bits).
  function automatic logic [pmd_pkg::PosW-1:0] clamp_axis(input int pos, input int move,
      input logic [pmd_pkg::SizeW-1:0] size);
    int lim;
    int sum;
    lim = size;
    if (lim < 1) lim = 1;
    if (lim > pmd_pkg::SizeMax) lim = pmd_pkg::SizeMax;
    sum = pos + move;
    if (sum < 0) sum = 0;
    if (sum >= lim) sum = lim - 1;
    return sum[pmd_pkg::PosW-1:0];
  endfunction

  // Advance the tracker by one accepted byte; a finished packet queues a report.
  task automatic track_mouse_byte(input logic [7:0] b);
    cursor_report_t rep;
    int             move_x;
    int             raw_y;
    int             move_y;
    if (!synced) begin
      // Nothing counts until the mouse acknowledges; afterwards 0xFA is plain data.
      if (b == pmd_pkg::AckByte) synced = 1'b1;
    end else begin
      case (frame_pos)
        FrameHeader: begin
          // Header without the always-one bit: drop it and stay put to resync.
          if (b[pmd_pkg::SyncBit]) begin
            hdr_byte  = b;
            frame_pos = FrameDx;
          end
        end
        FrameDx: begin
          dx_byte   = b;
          frame_pos = FrameDy;
        end
        default: begin
          frame_pos = FrameHeader;
          move_x    = $signed({hdr_byte[pmd_pkg::XSignBit], dx_byte});
          raw_y     = $signed({hdr_byte[pmd_pkg::YSignBit], b});
          move_y    = -raw_y;  // screen y grows downward
          pos_x     = clamp_axis(pos_x, move_x, scr_width);
          pos_y     = clamp_axis(pos_y, move_y, scr_height);
          rep.buttons   = hdr_byte[2:0];
          rep.delta_x   = move_x[8:0];
          rep.delta_y   = move_y[9:0];
          rep.pointer_x = pos_x;
          rep.pointer_y = pos_y;
          pending_reports.push_back(rep);
        end
      endcase
    end
  endtask

  // Byte driver: holds an offered byte until taken, then maybe idles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        track_mouse_byte(in_if.mouse_byte);
        void'(mouse_bytes_q.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (mouse_bytes_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_if.valid      <= 1'b1;
          in_if.mouse_byte <= mouse_bytes_q[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor: random back-pressure plus field-by-field check.
  always @(posedge clk_i) begin
    cursor_report_t exp_rep;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_reports.size() == 0) begin
          $error("report with no packet pending: buttons %0d dx %0d dy %0d x %0d y %0d",
                 out_if.buttons, out_if.delta_x, out_if.delta_y,
                 out_if.pointer_x, out_if.pointer_y);
          fail_count++;
        end else begin
          exp_rep = pending_reports.pop_front();
          if (out_if.buttons !== exp_rep.buttons) begin
            $error("buttons: expected %0d, got %0d", exp_rep.buttons, out_if.buttons);
            fail_count++;
          end
          if (out_if.delta_x !== exp_rep.delta_x) begin
            $error("delta_x: expected %0d, got %0d", exp_rep.delta_x, out_if.delta_x);
            fail_count++;
          end
          if (out_if.delta_y !== exp_rep.delta_y) begin
            $error("delta_y: expected %0d, got %0d", exp_rep.delta_y, out_if.delta_y);
            fail_count++;
          end
          if (out_if.pointer_x !== exp_rep.pointer_x) begin
            $error("pointer_x: expected %0d, got %0d", exp_rep.pointer_x, out_if.pointer_x);
            fail_count++;
          end
          if (out_if.pointer_y !== exp_rep.pointer_y) begin
            $error("pointer_y: expected %0d, got %0d", exp_rep.pointer_y, out_if.pointer_y);
            fail_count++;
          end
        end
      end
      out_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Long receiver hold-off, timed here so the sequencer can keep feeding bytes.
  initial begin
    forever begin
      @(hold_off_go);
      rx_hold <= 1'b1;
      repeat (HoldOffCycles) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  task automatic push_packet(input logic [7:0] hdr, input logic [7:0] dx,
                             input logic [7:0] dy);
    mouse_bytes_q.push_back(hdr);
    mouse_bytes_q.push_back(dx);
    mouse_bytes_q.push_back(dy);
  endtask

  // Mostly well-formed packets; half of them lean one way per call so the
  // cursor actually reaches the screen edges. The rest is loose bytes that
  // knock the framing off and force resyncs.
  task automatic queue_random_traffic(input int n_bytes);
    int         pushed;
    logic       lean_x;
    logic       lean_y;
    logic [7:0] hdr;
    pushed = 0;
    lean_x = 1'($urandom_range(1));
    lean_y = 1'($urandom_range(1));
    while (pushed < n_bytes) begin
      if ($urandom_range(99) < 85) begin
        hdr                   = 8'($urandom_range(255));
        hdr[pmd_pkg::SyncBit] = 1'b1;
        if ($urandom_range(1) == 1) begin
          hdr[pmd_pkg::XSignBit] = lean_x;
          hdr[pmd_pkg::YSignBit] = lean_y;
        end
        push_packet(hdr, 8'($urandom_range(255)), 8'($urandom_range(255)));
        pushed += 3;
      end else begin
        mouse_bytes_q.push_back(8'($urandom_range(255)));
        pushed++;
      end
    end
  endtask

  // Config write; valid stays high so back-to-back writes need no gap.
  // The caller drops valid after the last one.
  task automatic write_screen_reg(input logic [pmd_pkg::CfgIdxW-1:0] idx,
                                  input logic [pmd_pkg::SizeW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      pmd_pkg::RegScreenWidth:  scr_width  = val;
      pmd_pkg::RegScreenHeight: scr_height = val;
      default: ;
    endcase
  endtask

  // Sender stops here until every report is back and the pipe has settled.
  task automatic wait_drained();
    while (mouse_bytes_q.size() != 0 || pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Sequencer: reset, directed packets, then phases of screen sizes and idle shapes.
  initial begin
    logic [pmd_pkg::SizeW-1:0] width_plan[1:7];
    logic [pmd_pkg::SizeW-1:0] height_plan[1:7];
    in_if.valid      = 1'b0;
    in_if.mouse_byte = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;

    // Zero and oversized sizes, the 1-pixel screen, the full 4096 screen,
    // an ordinary mode, a random one and a 2-wide one of random height.
    width_plan  = '{13'd0, 13'd4096, 13'd8191, 13'd1, 13'd640, 13'd1024, 13'd2};
    height_plan = '{13'd0, 13'd4096, 13'd4097, 13'd1, 13'd480, 13'd768, 13'd8191};
    width_plan[6]  = 13'($urandom_range(4096, 1));
    height_plan[6] = 13'($urandom_range(4096, 1));
    height_plan[7] = 13'($urandom_range(4096, 1));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset sizes. Before the acknowledge everything is
    // ignored, even a byte that looks like a header.
    mouse_bytes_q.push_back(8'h08);
    mouse_bytes_q.push_back(8'h00);
    mouse_bytes_q.push_back(8'hFF);
    mouse_bytes_q.push_back(pmd_pkg::AckByte);
    push_packet(8'h08, 8'hFF, 8'h00);  // largest positive dx, no dy
    push_packet(8'h3F, 8'h00, 8'h00);  // all buttons, dx -256, dy +256 after negation
    push_packet(8'h18, 8'h01, 8'h80);  // dx -255, dy -128
    push_packet(8'h28, 8'h7F, 8'hFF);  // dy -1 flips to +1
    mouse_bytes_q.push_back(8'h00);    // bad header, dropped
    mouse_bytes_q.push_back(8'hF7);    // every bit but the sync bit, dropped
    push_packet(8'h08, pmd_pkg::AckByte, pmd_pkg::AckByte);  // acknowledge value now plain data
    push_packet(8'hFF, 8'hFF, 8'hFF);
    wait_drained();
    queue_random_traffic(125);
    wait_drained();

    for (int ph = 1; ph <= 7; ph++) begin
      write_screen_reg(pmd_pkg::RegScreenWidth, width_plan[ph]);
      write_screen_reg(pmd_pkg::RegScreenHeight, height_plan[ph]);
      if (ph == 4) write_screen_reg(RegUnused, 13'($urandom_range(8191)));
      cfg_if.valid <= 1'b0;

      if (ph == 6) begin
        // Full-rate sender against a blocked receiver: output register
        // fills and the block has to stall its byte input.
        tx_idle_pct  <= 0;
        rx_stall_pct <= 0;
        queue_random_traffic(250);
        -> hold_off_go;
      end else begin
        // Cycle through: no idling, sender idle, receiver stalls, both light.
        case (ph % 4)
          0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
          1: begin tx_idle_pct <= 67; rx_stall_pct <= 0;  end
          2: begin tx_idle_pct <= 0;  rx_stall_pct <= 67; end
          default: begin tx_idle_pct <= 16; rx_stall_pct <= 16; end
        endcase
        queue_random_traffic(125);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("ps2_mouse_packet_decoder_top_tb: clean");
    end else begin
      $display("ps2_mouse_packet_decoder_top_tb: errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(12 * 400000);
    $display("ps2_mouse_packet_decoder_top_tb: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/pmd_pkg.sv
rtl/pmd_byte_if.sv
rtl/pmd_result_if.sv
rtl/pmd_cfg_if.sv
rtl/pmd_framer.sv
rtl/pmd_cursor.sv
rtl/ps2_mouse_packet_decoder_top.sv
bench/ps2_mouse_packet_decoder_top_tb.sv
